@@ hdl/necd_pkg.sv @@
// necd_pkg: shared types, register codes, reset values and window test
// for the nec ir frame decoder; no dependencies
package necd_pkg;

	localparam int unsigned CNT_W           = 16;
	localparam int unsigned WORD_BITS       = 32;
	localparam int unsigned BIT_IDX_W       = 5;
	localparam int unsigned CFG_IDX_W       = 3;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned FRAME_BITS_DEF  = 32;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [BIT_IDX_W-1:0] bit_idx_t;

	// configuration register indexes
	localparam cfg_idx_t REG_START  = 3'd0;
	localparam cfg_idx_t REG_REPEAT = 3'd1;
	localparam cfg_idx_t REG_ZERO   = 3'd2;
	localparam cfg_idx_t REG_ONE    = 3'd3;
	localparam cfg_idx_t REG_TOL    = 3'd4;

	// register reset values
	localparam cnt_t START_RST  = 16'd12442;
	localparam cnt_t REPEAT_RST = 16'd10369;
	localparam cnt_t ZERO_RST   = 16'd1032;
	localparam cnt_t ONE_RST    = 16'd2074;
	localparam cnt_t TOL_RST    = 16'd500;

	// result kind
	typedef enum logic {
		EV_FRAME  = 1'b0,
		EV_REPEAT = 1'b1
	} ev_kind_t;

	// decoder phase
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_ARMED = 3'b010,
		PH_DATA  = 3'b100
	} phase_t;

	// window hits of one interval
	typedef struct packed {
		logic start;
		logic rpt;
		logic zero;
		logic one;
	} cls_t;

	// queue status towards front and back
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// center +/- tolerance, inclusive, no wrap on either bound
	function automatic logic in_window(cnt_t v, cnt_t c, cnt_t tol);
		logic [CNT_W:0] v_plus;
		logic [CNT_W:0] c_plus;
		v_plus = {1'b0, v} + {1'b0, tol};
		c_plus = {1'b0, c} + {1'b0, tol};
		return (v_plus >= {1'b0, c}) && ({1'b0, v} <= c_plus);
	endfunction

	function automatic logic bytes_ok(word_t w);
		return (w[7:0] == ~w[15:8]) && (w[23:16] == ~w[31:24]);
	endfunction

endpackage

@@ hdl/necd_if.sv @@
// channel interfaces of the nec ir frame decoder: edge items, event items
// and configuration writes; depends on necd_pkg
interface necd_edge_if import necd_pkg::*; ();
	logic valid;
	logic ready;
	cnt_t edge_interval;
	modport source (output valid, output edge_interval, input ready);
	modport sink   (input valid, input edge_interval, output ready);
endinterface

interface necd_event_if import necd_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  event_kind;
	byte_t address_byte;
	byte_t command_byte;
	modport source (output valid, output event_kind, output address_byte,
		output command_byte, input ready);
	modport sink   (input valid, input event_kind, input address_byte,
		input command_byte, output ready);
endinterface

interface necd_cfg_if import necd_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cnt_t     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/necd_front.sv @@
// necd_front: configuration registers and interval classification
// depends on necd_pkg and necd_if
module necd_front import necd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	necd_cfg_if.sink      cfg_ch,
	necd_edge_if.sink     edge_ch,
	input  q_stat_t       q_stat,
	output logic          push,
	output cls_t          push_cls
);

	cnt_t start_q, repeat_q, zero_q, one_q, tol_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RST;
			repeat_q <= REPEAT_RST;
			zero_q   <= ZERO_RST;
			one_q    <= ONE_RST;
			tol_q    <= TOL_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_START:  start_q  <= cfg_ch.data;
				REG_REPEAT: repeat_q <= cfg_ch.data;
				REG_ZERO:   zero_q   <= cfg_ch.data;
				REG_ONE:    one_q    <= cfg_ch.data;
				REG_TOL:    tol_q    <= cfg_ch.data;
				default:    ;
			endcase
		end
	end

	assign edge_ch.ready = !q_stat.full;
	assign push          = edge_ch.valid && edge_ch.ready;

	always_comb begin
		push_cls.start = in_window(edge_ch.edge_interval, start_q, tol_q);
		push_cls.rpt   = in_window(edge_ch.edge_interval, repeat_q, tol_q);
		push_cls.zero  = in_window(edge_ch.edge_interval, zero_q, tol_q);
		push_cls.one   = in_window(edge_ch.edge_interval, one_q, tol_q);
	end

endmodule

@@ hdl/necd_queue.sv @@
// necd_queue: short fifo of classified items between front and back
// depends on necd_pkg
module necd_queue import necd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cls_t    push_cls,
	input  logic    pop,
	output cls_t    pop_cls,
	output q_stat_t stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	cls_t          mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cls;
		end
	end

	assign pop_cls    = mem[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/necd_back.sv @@
// necd_back: phase sequencer, frame assembly, byte check and event register
// depends on necd_pkg and necd_if
module necd_back import necd_pkg::*; #(
	parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  q_stat_t       q_stat,
	input  cls_t          pop_cls,
	output logic          pop,
	necd_event_if.source  event_ch
);

	localparam bit_idx_t LAST_BIT = BIT_IDX_W'(FRAME_BITS - 1);

	phase_t   phase_q, phase_nxt;
	bit_idx_t bit_idx_q, bit_idx_nxt;
	word_t    frame_q, frame_nxt;
	byte_t    last_addr_q, last_cmd_q, last_addr_nxt, last_cmd_nxt;
	logic     emit;
	ev_kind_t emit_kind;
	logic     out_valid_q;
	ev_kind_t out_kind_q;
	byte_t    out_addr_q, out_cmd_q;

	assign pop = !q_stat.empty && (!out_valid_q || event_ch.ready);

	always_comb begin
		phase_nxt     = phase_q;
		bit_idx_nxt   = bit_idx_q;
		frame_nxt     = frame_q;
		last_addr_nxt = last_addr_q;
		last_cmd_nxt  = last_cmd_q;
		emit          = 1'b0;
		emit_kind     = EV_FRAME;
		case (phase_q)
			PH_ARMED: begin
				if (pop_cls.start) begin
					phase_nxt = PH_DATA;
				end else if (pop_cls.rpt) begin
					phase_nxt = PH_IDLE;
					emit      = 1'b1;
					emit_kind = EV_REPEAT;
				end
			end
			PH_DATA: begin
				if (!pop_cls.zero && !pop_cls.one) begin
					bit_idx_nxt = '0;
					phase_nxt   = PH_ARMED;
				end else begin
					frame_nxt[bit_idx_q] = !pop_cls.zero;
					if (bit_idx_q == LAST_BIT) begin
						bit_idx_nxt = '0;
						phase_nxt   = PH_IDLE;
						if (bytes_ok(frame_nxt)) begin
							last_addr_nxt = frame_nxt[7:0];
							last_cmd_nxt  = frame_nxt[23:16];
							emit          = 1'b1;
						end
					end else begin
						bit_idx_nxt = bit_idx_q + 1'b1;
					end
				end
			end
			default: phase_nxt = PH_ARMED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_idx_q   <= '0;
			frame_q     <= '0;
			last_addr_q <= '0;
			last_cmd_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_nxt;
				bit_idx_q   <= bit_idx_nxt;
				frame_q     <= frame_nxt;
				last_addr_q <= last_addr_nxt;
				last_cmd_q  <= last_cmd_nxt;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (event_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_kind_q <= emit_kind;
			out_addr_q <= last_addr_nxt;
			out_cmd_q  <= last_cmd_nxt;
		end
	end

	assign event_ch.valid        = out_valid_q;
	assign event_ch.event_kind   = out_kind_q;
	assign event_ch.address_byte = out_addr_q;
	assign event_ch.command_byte = out_cmd_q;

endmodule

@@ hdl/nec_ir_frame_decoder_top.sv @@
// nec_ir_frame_decoder_top: nec infrared frame decoder, front, queue and back
// depends on necd_pkg, necd_if, necd_front, necd_queue, necd_back
//
// usage
// - edge_ch: one item per falling edge of the ir receiver, carrying the
//   timer count since the previous edge (edge_interval)
// - event_ch: zero or one item per edge item; event_kind 0 is a checked
//   frame with its address and command bytes, 1 is a repeat code that
//   re-reports the last good frame's address and command
// - cfg_ch: register writes (index 0 start, 1 repeat, 2 zero, 3 one centre,
//   4 tolerance), always ready; write only while the decoder is quiet
// timing
// - an edge item is classified against the windows in the cycle it is
//   accepted and lands in the queue; the back end takes it once the output
//   register is free or being read, and its event is registered there
// - one edge item per cycle, sustained while event_ch does not stall; the
//   back end's phase update is the pacing loop
// - while event_ch stalls with an event pending, edges keep coming in until
//   the queue (QUEUE_DEPTH items) fills, then edge_ch.ready drops
// reset
// - arst_n clears the queue, the output valid flag and the phase (idle) and
//   restores every configuration register to its default
module nec_ir_frame_decoder_top import necd_pkg::*; #(
	parameter int unsigned FRAME_BITS  = FRAME_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	necd_edge_if.sink     edge_ch,
	necd_event_if.source  event_ch,
	necd_cfg_if.sink      cfg_ch
);

	// front to queue
	logic    push;
	cls_t    push_cls;
	// queue to back
	logic    pop;
	cls_t    pop_cls;
	q_stat_t q_stat;

	// window classification and configuration registers
	necd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_ch   (cfg_ch),
		.edge_ch  (edge_ch),
		.q_stat   (q_stat),
		.push     (push),
		.push_cls (push_cls)
	);

	// short decoupling queue of classified items
	necd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cls (push_cls),
		.pop      (pop),
		.pop_cls  (pop_cls),
		.stat     (q_stat)
	);

	// phase sequencer, frame assembly and output register
	necd_back #(
		.FRAME_BITS (FRAME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_cls  (pop_cls),
		.pop      (pop),
		.event_ch (event_ch)
	);

`ifndef SYNTHESIS
	// back end never takes from an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// an item pushed without a pop leaves the queue occupied
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !q_stat.empty)
		else $error("pushed item lost");

	// a fresh event only follows a pop from the queue
	a_event_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(event_ch.valid) |-> $past(pop))
		else $error("event without a queued item");
`endif

endmodule
